### hdl/ihv_pkg.sv
// Shared types and constants for the IPv4 header validator.
package ihv_pkg;

   // Defaults for the top-level parameters
   localparam int DEFAULT_LINK_HEADER_BYTES = 14;
   localparam int DEFAULT_LENGTH_BITS       = 16;

   // Fixed field widths
   localparam int COUNT_BITS = 16;
   localparam int SUM_BITS   = 17;

   // IPv4 header constants
   localparam logic [3:0]  IP_VERSION    = 4'd4;
   localparam logic [3:0]  IP_MIN_IHL    = 4'd5;
   localparam logic [15:0] IP_MIN_HEADER = 16'd20;
   localparam logic [15:0] CSUM_ALL_ONES = 16'hffff;

   // Byte offsets inside the IPv4 header
   localparam int OFF_VER_IHL  = 0;
   localparam int OFF_TOTAL_HI = 2;
   localparam int OFF_TOTAL_LO = 3;
   localparam int OFF_TTL      = 8;
   localparam int OFF_CSUM_HI  = 10;
   localparam int OFF_CSUM_LO  = 11;

   // Verdict codes
   localparam logic [2:0] FAIL_NONE     = 3'd0;
   localparam logic [2:0] FAIL_SHORT    = 3'd1;
   localparam logic [2:0] FAIL_VER_IHL  = 3'd2;
   localparam logic [2:0] FAIL_TOTAL    = 3'd3;
   localparam logic [2:0] FAIL_CHECKSUM = 3'd4;
   localparam logic [2:0] FAIL_TTL      = 3'd5;

   // Frame queue sizing
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Summary of one finished frame, handed from front to back
   typedef struct packed {
      logic [COUNT_BITS-1:0] frame_bytes;
      logic [3:0]            version;
      logic [3:0]            ihl;
      logic [15:0]           total_length;
      logic [7:0]            ttl;
      logic [15:0]           rx_checksum;
      logic [SUM_BITS-1:0]   sum;
   } frame_rec_type;

endpackage

### hdl/ihv_front.sv
// Front end: byte counter, header field capture and checksum accumulation.
module ihv_front #(
   parameter int LINK_HEADER_BYTES = ihv_pkg::DEFAULT_LINK_HEADER_BYTES,
   parameter int LENGTH_BITS       = ihv_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_frame_byte,
   input  logic                  req_end_of_frame,
   input  logic                  queue_full,
   output logic                  push,
   output ihv_pkg::frame_rec_type push_rec
);

   localparam int LB = LENGTH_BITS;
   localparam logic [LB-1:0] LINK_POS  = LB'(LINK_HEADER_BYTES);
   localparam logic [LB-1:0] O_VER_IHL = LB'(ihv_pkg::OFF_VER_IHL);
   localparam logic [LB-1:0] O_TOT_HI  = LB'(ihv_pkg::OFF_TOTAL_HI);
   localparam logic [LB-1:0] O_TOT_LO  = LB'(ihv_pkg::OFF_TOTAL_LO);
   localparam logic [LB-1:0] O_TTL     = LB'(ihv_pkg::OFF_TTL);
   localparam logic [LB-1:0] O_CS_HI   = LB'(ihv_pkg::OFF_CSUM_HI);
   localparam logic [LB-1:0] O_CS_LO   = LB'(ihv_pkg::OFF_CSUM_LO);

   logic [LB-1:0] pos_ff, pos_in;
   logic [ihv_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [7:0]  held_ff, held_in;
   logic [3:0]  ver_ff, ver_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [15:0] csum_ff, csum_in;

   logic          accept;
   logic          in_ip;
   logic [LB-1:0] off;
   logic          in_hdr;
   logic [15:0]   word;
   logic [ihv_pkg::SUM_BITS-1:0] sum_raw;

   // Stall every byte while no slot is free for a verdict
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && req_end_of_frame;

   assign in_ip = (pos_ff >= LINK_POS);
   assign off   = pos_ff - LINK_POS;

   // Next state for the current byte
   always_comb begin
      pos_in   = (&pos_ff) ? pos_ff : pos_ff + LB'(1);
      sum_in   = sum_ff;
      held_in  = held_ff;
      ver_in   = ver_ff;
      ihl_in   = ihl_ff;
      total_in = total_ff;
      ttl_in   = ttl_ff;
      csum_in  = csum_ff;
      in_hdr   = 1'b0;
      word     = 16'd0;
      sum_raw  = '0;

      if (in_ip) begin
         // Field capture
         if (off == O_VER_IHL) begin
            ver_in = req_frame_byte[7:4];
            ihl_in = req_frame_byte[3:0];
         end
         if (off == O_TOT_HI) total_in[15:8] = req_frame_byte;
         if (off == O_TOT_LO) total_in[7:0]  = req_frame_byte;
         if (off == O_TTL)    ttl_in         = req_frame_byte;
         if (off == O_CS_HI)  csum_in[15:8]  = req_frame_byte;
         if (off == O_CS_LO)  csum_in[7:0]   = req_frame_byte;

         // Header sum uses the IHL as just updated
         in_hdr = (off < {{(LB-6){1'b0}}, ihl_in, 2'b00});
         if (in_hdr) begin
            if (!off[0]) begin
               held_in = req_frame_byte;
            end else begin
               // checksum field counts as zero
               word    = (off == O_CS_LO) ? 16'd0 : {held_ff, req_frame_byte};
               sum_raw = sum_ff + {1'b0, word};
               sum_in  = {1'b0, sum_raw[15:0]} + {16'd0, sum_raw[16]};
            end
         end
      end
   end

   // Summary of the frame as of its last byte
   always_comb begin
      push_rec.frame_bytes  = ihv_pkg::COUNT_BITS'(pos_in);
      push_rec.version      = ver_in;
      push_rec.ihl          = ihl_in;
      push_rec.total_length = total_in;
      push_rec.ttl          = ttl_in;
      push_rec.rx_checksum  = csum_in;
      push_rec.sum          = sum_in;
   end

   // Frame state, cleared after each last byte
   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         held_ff  <= '0;
         ver_ff   <= '0;
         ihl_ff   <= '0;
         total_ff <= '0;
         ttl_ff   <= '0;
         csum_ff  <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         held_ff  <= held_in;
         ver_ff   <= ver_in;
         ihl_ff   <= ihl_in;
         total_ff <= total_in;
         ttl_ff   <= ttl_in;
         csum_ff  <= csum_in;
      end
   end

endmodule

### hdl/ihv_queue.sv
// Short queue of finished-frame summaries between front and back.
module ihv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ihv_pkg::frame_rec_type push_rec,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output ihv_pkg::frame_rec_type head_rec
);

   localparam int PB = ihv_pkg::QPTR_BITS;
   localparam int CB = ihv_pkg::QCNT_BITS;
   localparam logic [PB-1:0] LAST_SLOT = PB'(ihv_pkg::QUEUE_DEPTH - 1);
   localparam logic [CB-1:0] DEPTH     = CB'(ihv_pkg::QUEUE_DEPTH);

   ihv_pkg::frame_rec_type slots_ff [ihv_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ff, wr_in;
   logic [PB-1:0] rd_ff, rd_in;
   logic [CB-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == DEPTH);
   assign not_empty = (cnt_ff != '0);
   assign head_rec  = slots_ff[rd_ff];

   // Pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PB'(1);
      if (pop)  rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PB'(1);
      if (push && !pop) cnt_in = cnt_ff + CB'(1);
      if (pop && !push) cnt_in = cnt_ff - CB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ff] <= push_rec;
   end

endmodule

### hdl/ihv_back.sv
// Back end: runs the header checks on a frame summary and holds the verdict.
module ihv_back #(
   parameter int LINK_HEADER_BYTES = ihv_pkg::DEFAULT_LINK_HEADER_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rec_valid,
   input  ihv_pkg::frame_rec_type rec,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_header_ok,
   output logic [2:0]            rsp_fail_reason,
   output logic [15:0]           rsp_frame_bytes
);

   localparam logic [16:0] LINK_LEN = 17'(LINK_HEADER_BYTES);

   logic        rsp_valid_ff, rsp_valid_in;
   logic        ok_ff;
   logic [2:0]  reason_ff;
   logic [15:0] bytes_ff;

   logic [16:0] count;
   logic [15:0] folded;
   logic [15:0] computed;
   logic [2:0]  reason;

   // Load a new verdict when the output register is empty or drains now
   assign pop = rec_valid && (!rsp_valid_ff || !rsp_stall);

   // Checks in priority order
   always_comb begin
      count    = {1'b0, rec.frame_bytes};
      folded   = rec.sum[15:0] + {15'd0, rec.sum[16]};
      computed = ~folded;
      if (computed == 16'd0) computed = ihv_pkg::CSUM_ALL_ONES;

      if (count < LINK_LEN + {1'b0, ihv_pkg::IP_MIN_HEADER}) begin
         reason = ihv_pkg::FAIL_SHORT;
      end else if (rec.version != ihv_pkg::IP_VERSION || rec.ihl < ihv_pkg::IP_MIN_IHL) begin
         reason = ihv_pkg::FAIL_VER_IHL;
      end else if (count < LINK_LEN + {11'd0, rec.ihl, 2'b00}) begin
         reason = ihv_pkg::FAIL_SHORT;
      end else if (rec.total_length < ihv_pkg::IP_MIN_HEADER ||
                   count < LINK_LEN + {1'b0, rec.total_length}) begin
         reason = ihv_pkg::FAIL_TOTAL;
      end else if (computed != rec.rx_checksum) begin
         reason = ihv_pkg::FAIL_CHECKSUM;
      end else if (rec.ttl == 8'd0) begin
         reason = ihv_pkg::FAIL_TTL;
      end else begin
         reason = ihv_pkg::FAIL_NONE;
      end
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop)                                rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // Verdict payload
   always_ff @(posedge clock) begin
      if (pop) begin
         ok_ff     <= (reason == ihv_pkg::FAIL_NONE);
         reason_ff <= reason;
         bytes_ff  <= rec.frame_bytes;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_header_ok   = ok_ff;
   assign rsp_fail_reason = reason_ff;
   assign rsp_frame_bytes = bytes_ff;

endmodule

### hdl/ipv4_header_validator_unit.sv
// Top level of the IPv4 header validator: front end, frame queue, back end.
//
//   channel | direction | ports                                   | transfer
//   --------+-----------+-----------------------------------------+-------------------------
//   req     | in        | frame_byte, end_of_frame                | req_valid & !req_stall
//   rsp     | out       | header_ok, fail_reason, frame_bytes     | rsp_valid & !rsp_stall
//
// One byte is taken every cycle unless req_stall; one folded add per 16-bit header word.
// A frame's summary is queued at its last byte; the back end then registers its verdict.
// req_stall rises only while the two-entry frame queue is full, which happens when
// rsp_stall holds back three pending verdicts: one in the output register, two queued.
// Synchronous reset clears the byte counter, header capture, queue and rsp_valid.
module ipv4_header_validator_unit #(
   parameter int LINK_HEADER_BYTES = ihv_pkg::DEFAULT_LINK_HEADER_BYTES,
   parameter int LENGTH_BITS       = ihv_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_header_ok,
   output logic [2:0]  rsp_fail_reason,
   output logic [15:0] rsp_frame_bytes
);

   logic                   q_push;
   logic                   q_pop;
   logic                   q_full;
   logic                   q_not_empty;
   ihv_pkg::frame_rec_type q_push_rec;
   ihv_pkg::frame_rec_type q_head_rec;

   ihv_front #(
      .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
      .LENGTH_BITS       (LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_byte   (req_frame_byte),
      .req_end_of_frame (req_end_of_frame),
      .queue_full       (q_full),
      .push             (q_push),
      .push_rec         (q_push_rec)
   );

   ihv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (q_push_rec),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_rec  (q_head_rec)
   );

   ihv_back #(
      .LINK_HEADER_BYTES (LINK_HEADER_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .rec_valid       (q_not_empty),
      .rec             (q_head_rec),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_ok   (rsp_header_ok),
      .rsp_fail_reason (rsp_fail_reason),
      .rsp_frame_bytes (rsp_frame_bytes)
   );

   // No verdict is presented right after reset
   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // A passing verdict carries no failure code
   a_ok_matches_reason : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_header_ok == (rsp_fail_reason == ihv_pkg::FAIL_NONE)))
      else $error("header_ok disagrees with fail_reason");

   // A passing frame holds at least the link header and a minimal IPv4 header
   a_ok_long_enough : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_header_ok) |->
         ({1'b0, rsp_frame_bytes} >=
          17'(LINK_HEADER_BYTES) + {1'b0, ihv_pkg::IP_MIN_HEADER}))
      else $error("passing frame shorter than its headers");

   // Bytes are refused only while the frame queue has no free slot
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (q_not_empty && rsp_valid))
      else $error("input stalled with room in the queue");

endmodule
